FILE: hdl/aqi_pkg.sv
`default_nettype none

package aqi_pkg;

    // Pollutant selector codes.
    typedef enum logic [1:0] {
        MODE_OZONE = 2'd0,
        MODE_PM25  = 2'd1,
        MODE_PM10  = 2'd2,
        MODE_OTHER = 2'd3
    } mode_t;

    // Field and datapath widths.
    localparam int CONC_W  = 16;  // concentration input
    localparam int AQI_W   = 16;  // index output
    localparam int TAB_W   = 13;  // breakpoint values, largest is 5004
    localparam int DEN_W   = 12;  // segment width, largest is 2499
    localparam int ADIFF_W = 8;   // index span of a segment, largest is 199
    localparam int BASE_W  = 9;   // segment index low bound, largest is 301
    localparam int SEG_W   = 3;   // segment number
    localparam int NUM_W   = CONC_W + ADIFF_W;  // product (c - lo) * span
    localparam int N_W     = NUM_W + 2;         // 2 * product + width
    localparam int REM_W   = DEN_W + 1;         // divisor is 2 * width
    localparam int Q_W     = 16;                // quotient bits, one per cell

    localparam int NUM_SEG = 6;
    localparam int NUM_TAB = 3;

    localparam logic [TAB_W-1:0] OTHER_HI = 13'd604;

    // Breakpoints per pollutant, in fixed units.
    localparam logic [TAB_W-1:0] CONC_LO [NUM_TAB][NUM_SEG] = '{
        '{13'd0, 13'd55,  13'd71,  13'd86,  13'd106,  13'd201},
        '{13'd0, 13'd121, 13'd355, 13'd555, 13'd1505, 13'd2505},
        '{13'd0, 13'd55,  13'd155, 13'd255, 13'd355,  13'd425}
    };
    localparam logic [TAB_W-1:0] CONC_HI [NUM_TAB][NUM_SEG] = '{
        '{13'd54,  13'd70,  13'd85,  13'd105,  13'd200,  13'd300},
        '{13'd120, 13'd354, 13'd554, 13'd1504, 13'd2504, 13'd5004},
        '{13'd54,  13'd154, 13'd254, 13'd354,  13'd424,  13'd604}
    };

    // Index bounds per segment.
    localparam logic [BASE_W-1:0] AQI_LO [NUM_SEG] = '{
        9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301
    };
    localparam logic [BASE_W-1:0] AQI_HI [NUM_SEG] = '{
        9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd500
    };

    // Data handed from cell to cell along the divider row.
    // The dq field holds the dividend bits still to be shifted in at its top and the
    // quotient bits already found at its bottom.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [Q_W-1:0]    dq;
        logic [REM_W-1:0]  div;
        logic [BASE_W-1:0] base;
    } cell_data_t;

endpackage

`default_nettype wire

FILE: hdl/aqi_front.sv
`default_nettype none

module aqi_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 mode,
    input  wire logic [aqi_pkg::CONC_W-1:0] concentration,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output aqi_pkg::cell_data_t             out_data
);

    localparam int PAD_W = aqi_pkg::CONC_W - aqi_pkg::TAB_W;

    logic                              other;
    logic [1:0]                        row;
    logic [aqi_pkg::SEG_W-1:0]         seg;
    logic [aqi_pkg::TAB_W-1:0]         clo;
    logic [aqi_pkg::TAB_W-1:0]         chi;
    logic [aqi_pkg::TAB_W-1:0]         den_full;
    logic [aqi_pkg::BASE_W-1:0]        span_full;

    logic                              s1_valid_reg;
    logic [aqi_pkg::CONC_W-1:0]        s1_cdiff_reg;
    logic [aqi_pkg::ADIFF_W-1:0]       s1_adiff_reg;
    logic [aqi_pkg::DEN_W-1:0]         s1_den_reg;
    logic [aqi_pkg::BASE_W-1:0]        s1_base_reg;

    logic                              s2_valid_reg;
    aqi_pkg::cell_data_t               s2_data_reg;
    aqi_pkg::cell_data_t               s2_data_next;

    logic                              s1_ready;
    logic                              s2_ready;
    logic [aqi_pkg::NUM_W-1:0]         num;
    logic [aqi_pkg::N_W-1:0]           dividend;

    // Segment search: six range checks against the selected breakpoint row.
    always_comb
    begin
        other = (aqi_pkg::mode_t'(mode) == aqi_pkg::MODE_OTHER);
        row   = other ? 2'd0 : mode;
        seg   = '0;
        for (int i = 0; i < aqi_pkg::NUM_SEG; i++)
        begin
            if (!other
                && concentration >  {{PAD_W{1'b0}}, aqi_pkg::CONC_LO[row][i]}
                && concentration <= {{PAD_W{1'b0}}, aqi_pkg::CONC_HI[row][i]})
            begin
                seg = aqi_pkg::SEG_W'(i);
            end
        end
        clo       = other ? '0 : aqi_pkg::CONC_LO[row][seg];
        chi       = other ? aqi_pkg::OTHER_HI : aqi_pkg::CONC_HI[row][seg];
        den_full  = chi - clo;
        span_full = aqi_pkg::AQI_HI[seg] - aqi_pkg::AQI_LO[seg];
    end

    // Handshake: a stage loads when it is empty or its content moves on.
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // Stage one: segment offsets.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_cdiff_reg <= concentration - {{PAD_W{1'b0}}, clo};
            s1_adiff_reg <= span_full[aqi_pkg::ADIFF_W-1:0];
            s1_den_reg   <= den_full[aqi_pkg::DEN_W-1:0];
            s1_base_reg  <= aqi_pkg::AQI_LO[seg];
        end
    end

    // Stage two: product and rounding term, split into the first partial remainder
    // and the bits that the divider cells shift in.  The quotient stays below 2^16,
    // so the top part is already smaller than the divisor.
    always_comb
    begin
        num      = aqi_pkg::NUM_W'(s1_cdiff_reg) * aqi_pkg::NUM_W'(s1_adiff_reg);
        dividend = {1'b0, num, 1'b0} + aqi_pkg::N_W'(s1_den_reg);
        s2_data_next.rem  = aqi_pkg::REM_W'(dividend[aqi_pkg::N_W-1:aqi_pkg::Q_W]);
        s2_data_next.dq   = dividend[aqi_pkg::Q_W-1:0];
        s2_data_next.div  = {s1_den_reg, 1'b0};
        s2_data_next.base = s1_base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/aqi_cell.sv
`default_nettype none

module aqi_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire aqi_pkg::cell_data_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output aqi_pkg::cell_data_t      out_data
);

    logic                      valid_reg;
    aqi_pkg::cell_data_t       data_reg;
    aqi_pkg::cell_data_t       data_next;
    logic [aqi_pkg::REM_W:0]   trial;
    logic                      qbit;

    // One restoring division step: shift in the next dividend bit and subtract
    // the divisor if it fits.
    always_comb
    begin
        trial = {in_data.rem, in_data.dq[aqi_pkg::Q_W-1]};
        qbit  = (trial >= {1'b0, in_data.div});
        data_next.rem  = qbit ? aqi_pkg::REM_W'(trial - {1'b0, in_data.div})
                              : trial[aqi_pkg::REM_W-1:0];
        data_next.dq   = {in_data.dq[aqi_pkg::Q_W-2:0], qbit};
        data_next.div  = in_data.div;
        data_next.base = in_data.base;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/air_quality_index_interpolator.sv
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid, in_ready   mode[1:0], concentration[15:0]
// output    out_valid, out_ready aqi[15:0]
//
// One transfer per cycle is accepted unless a stalled output backs up to the input;
// each item is worked on in a row of sixteen divider cells, one quotient bit per cell,
// after two front stages (segment search, then multiply), then the output register.
// Reset clears only the valid bits of every stage.
// A stalled output only holds the stages that are full; empty stages keep filling.

module air_quality_index_interpolator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 mode,
    input  wire logic [aqi_pkg::CONC_W-1:0] concentration,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [aqi_pkg::AQI_W-1:0]       aqi
);

    localparam int NUM_CELLS = aqi_pkg::Q_W;

    aqi_pkg::cell_data_t               stage_data [NUM_CELLS+1];
    logic [NUM_CELLS:0]                stage_valid;
    logic [NUM_CELLS:0]                stage_ready;

    logic                              out_valid_reg;
    logic [aqi_pkg::AQI_W-1:0]         aqi_reg;
    logic [aqi_pkg::AQI_W-1:0]         aqi_next;
    logic [aqi_pkg::Q_W:0]             sum;

    // Segment search and product.
    aqi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .concentration (concentration),
        .out_valid     (stage_valid[0]),
        .out_ready     (stage_ready[0]),
        .out_data      (stage_data[0])
    );

    // Row of divider cells.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        aqi_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // Add the segment's low index and saturate.
    always_comb
    begin
        sum      = {1'b0, stage_data[NUM_CELLS].dq}
                   + (aqi_pkg::Q_W+1)'(stage_data[NUM_CELLS].base);
        aqi_next = sum[aqi_pkg::Q_W] ? '1 : sum[aqi_pkg::AQI_W-1:0];
    end

    // Output register.
    assign stage_ready[NUM_CELLS] = !out_valid_reg || out_ready;
    assign out_valid              = out_valid_reg;
    assign aqi                    = aqi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_ready[NUM_CELLS])
        begin
            out_valid_reg <= stage_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[NUM_CELLS] && stage_valid[NUM_CELLS])
        begin
            aqi_reg <= aqi_next;
        end
    end

    // The first partial remainder must already be below the divisor.
    a_first_rem: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |-> (stage_data[0].rem < stage_data[0].div))
        else $error("partial remainder not below divisor at divider entry");

    // The final remainder stays below the divisor.
    a_last_rem: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[NUM_CELLS] |-> (stage_data[NUM_CELLS].rem < stage_data[NUM_CELLS].div))
        else $error("remainder not below divisor at divider exit");

    // With these tables the index never reaches the saturation limit.
    a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[NUM_CELLS] |-> !sum[aqi_pkg::Q_W])
        else $error("index sum overflowed");

    // An output that is being taken frees the whole row for a new transfer.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

endmodule

`default_nettype wire

FILE: verif/air_quality_index_interpolator_test.sv
`timescale 1ns / 100ps

module air_quality_index_interpolator_test;

    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned HANG_LIMIT   = 2000;
    // Drain time after the last result.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PER_PHASE = 107;
    localparam int unsigned NUM_PHASES   = 4;
    localparam int unsigned OTHER_TOP    = 604;

    // Breakpoints in fixed units, one row per pollutant with its own table.
    localparam int unsigned BP_CONC_LO [3][6] = '{
        '{0, 55, 71, 86, 106, 201},
        '{0, 121, 355, 555, 1505, 2505},
        '{0, 55, 155, 255, 355, 425}
    };
    localparam int unsigned BP_CONC_HI [3][6] = '{
        '{54, 70, 85, 105, 200, 300},
        '{120, 354, 554, 1504, 2504, 5004},
        '{54, 154, 254, 354, 424, 604}
    };
    localparam int unsigned BP_AQI_LO [6] = '{0, 51, 101, 151, 201, 301};
    localparam int unsigned BP_AQI_HI [6] = '{50, 100, 150, 200, 300, 500};

    typedef struct packed {
        aqi_pkg::mode_t m;
        logic [15:0]    conc;
        logic           typed;
        logic [15:0]    want;
    } reading_row_t;

    typedef struct packed {
        aqi_pkg::mode_t m;
        logic [15:0]    conc;
        logic [15:0]    aqi;
    } aqi_pending_t;

    // Directed readings. A typed value is given only where it is obvious:
    // zero concentration and the top of a segment, which lands on its index bound.
    localparam int NUM_DIRECTED = 24;
    reading_row_t directed_rows [NUM_DIRECTED] = '{
        '{aqi_pkg::MODE_OZONE, 16'd0,     1'b1, 16'd0},
        '{aqi_pkg::MODE_PM25,  16'd0,     1'b1, 16'd0},
        '{aqi_pkg::MODE_PM10,  16'd0,     1'b1, 16'd0},
        '{aqi_pkg::MODE_OTHER, 16'd0,     1'b1, 16'd0},
        '{aqi_pkg::MODE_OZONE, 16'd54,    1'b1, 16'd50},
        '{aqi_pkg::MODE_OZONE, 16'd300,   1'b1, 16'd500},
        '{aqi_pkg::MODE_PM25,  16'd120,   1'b1, 16'd50},
        '{aqi_pkg::MODE_PM25,  16'd5004,  1'b1, 16'd500},
        '{aqi_pkg::MODE_PM10,  16'd54,    1'b1, 16'd50},
        '{aqi_pkg::MODE_PM10,  16'd604,   1'b1, 16'd500},
        '{aqi_pkg::MODE_OTHER, 16'd604,   1'b1, 16'd50},
        '{aqi_pkg::MODE_OZONE, 16'd55,    1'b0, 16'd0},
        '{aqi_pkg::MODE_PM25,  16'd121,   1'b0, 16'd0},
        '{aqi_pkg::MODE_PM10,  16'd425,   1'b0, 16'd0},
        '{aqi_pkg::MODE_OZONE, 16'd301,   1'b0, 16'd0},
        '{aqi_pkg::MODE_PM25,  16'd5005,  1'b0, 16'd0},
        '{aqi_pkg::MODE_OZONE, 16'd65535, 1'b0, 16'd0},
        '{aqi_pkg::MODE_PM25,  16'd65535, 1'b0, 16'd0},
        '{aqi_pkg::MODE_PM10,  16'd65535, 1'b0, 16'd0},
        '{aqi_pkg::MODE_OTHER, 16'd65535, 1'b0, 16'd0},
        '{aqi_pkg::MODE_OTHER, 16'd1,     1'b0, 16'd0},
        '{aqi_pkg::MODE_OZONE, 16'd56,    1'b0, 16'd0},
        '{aqi_pkg::MODE_PM10,  16'd200,   1'b0, 16'd0},
        '{aqi_pkg::MODE_PM25,  16'd1000,  1'b0, 16'd0}
    };

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    aqi_pkg::mode_t mode = aqi_pkg::MODE_OZONE;
    logic [15:0]    concentration = 16'd0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [15:0]    aqi;

    // Typed expectation that travels with the reading being offered.
    logic        reading_typed = 1'b0;
    logic [15:0] reading_want = 16'd0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    aqi_pending_t aqi_expected [$];

    air_quality_index_interpolator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .concentration (concentration),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .aqi           (aqi)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Index for one reading: find the segment, then interpolate with round half up.
    function automatic logic [15:0] aqi_for_reading(aqi_pkg::mode_t m, logic [15:0] c);
        int unsigned      seg;
        int unsigned      idx;
        longint unsigned  lo;
        longint unsigned  hi;
        longint unsigned  prod;
        longint unsigned  width;
        longint unsigned  val;
        seg = 0;
        lo = 0;
        hi = OTHER_TOP;
        if (m != aqi_pkg::MODE_OTHER)
        begin
            for (idx = 0; idx < 6; idx++)
            begin
                if (c > BP_CONC_LO[int'(m)][idx] && c <= BP_CONC_HI[int'(m)][idx])
                    seg = idx;
            end
            lo = BP_CONC_LO[int'(m)][seg];
            hi = BP_CONC_HI[int'(m)][seg];
        end
        prod  = (longint'(c) - lo) * (BP_AQI_HI[seg] - BP_AQI_LO[seg]);
        width = hi - lo;
        val   = BP_AQI_LO[seg] + (2 * prod + width) / (2 * width);
        if (val > 64'hFFFF)
            val = 64'hFFFF;
        return val[15:0];
    endfunction

    // Random concentration, weighted toward the table range and its breakpoints.
    function automatic logic [15:0] pick_concentration(aqi_pkg::mode_t m);
        int unsigned pick;
        int unsigned top;
        int unsigned seg;
        int          edge_val;
        pick = $urandom_range(99);
        top = (m == aqi_pkg::MODE_OTHER) ? OTHER_TOP : BP_CONC_HI[int'(m)][5];
        seg = $urandom_range(5);
        if (pick < 50)
            return 16'($urandom_range(top, 0));
        if (pick < 75)
        begin
            if (m == aqi_pkg::MODE_OTHER)
                edge_val = $urandom_range(1) ? 0 : int'(OTHER_TOP);
            else
                edge_val = $urandom_range(1) ? int'(BP_CONC_LO[int'(m)][seg])
                                             : int'(BP_CONC_HI[int'(m)][seg]);
            edge_val = edge_val + int'($urandom_range(2)) - 1;
            if (edge_val < 0)
                edge_val = 0;
            return 16'(edge_val);
        end
        if (pick < 85)
            return 16'($urandom_range(top + 200, top + 1));
        return 16'($urandom_range(16'hFFFF, 0));
    endfunction

    task automatic report_mismatch(string what, aqi_pending_t want, logic [15:0] got);
        $display("MISMATCH %s: mode %s conc %0d, aqi got %0d want %0d",
                 what, want.m.name(), want.conc, got, want.aqi);
        mismatch_count++;
    endtask

    // Offer one reading, starting and ending on a falling edge.
    task automatic send_reading(aqi_pkg::mode_t m, logic [15:0] c, logic typed,
                                logic [15:0] want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        concentration <= c;
        reading_typed <= typed;
        reading_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the input off until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (aqi_expected.size() != 0)
            @(negedge clk);
    endtask

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Transfer monitor: records accepted readings, checks results, and
    // watches for a hung pipeline.
    always @(posedge clk)
    begin : monitor
        aqi_pending_t entry;
        aqi_pending_t head;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                entry.m    = mode;
                entry.conc = concentration;
                entry.aqi  = reading_typed ? reading_want
                                           : aqi_for_reading(mode, concentration);
                aqi_expected.push_back(entry);
            end
            if (out_valid && out_ready)
            begin
                if (aqi_expected.size() == 0)
                begin
                    head = '0;
                    report_mismatch("unexpected result", head, aqi);
                end
                else
                begin
                    head = aqi_expected.pop_front();
                    if (aqi !== head.aqi)
                        report_mismatch("aqi", head, aqi);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus: directed rows, then random readings in each of four phases with varied input idling and output stalls.
    initial
    begin : stimulus
        int unsigned    phase;
        int unsigned    n;
        aqi_pkg::mode_t m;
        reading_row_t   row;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 53;
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase
            if (phase == 0)
            begin
                for (n = 0; n < NUM_DIRECTED; n++)
                begin
                    row = directed_rows[n];
                    send_reading(row.m, row.conc, row.typed, row.want);
                end
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                m = aqi_pkg::mode_t'($urandom_range(3));
                send_reading(m, pick_concentration(m), 1'b0, 16'd0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && aqi_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hdl/aqi_pkg.sv
hdl/aqi_front.sv
hdl/aqi_cell.sv
hdl/air_quality_index_interpolator.sv
verif/air_quality_index_interpolator_test.sv
